>>> hw/rtl/bsst_pkg.sv
// Shared types, codes and field layout for the sorted-table search block.
package bsst_pkg;

    // Parameter defaults
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_W     = 32;

    // Field widths of the stream payloads
    localparam int IDX_W  = 10;
    localparam int WORD_W = 32;
    localparam int POS_W  = 10;

    // Signed bound width: holds -1 up to 1024
    localparam int BND_W = 12;

    // Input tdata layout, lowest bit first
    localparam int S_WIDX_LSB = 0;
    localparam int S_WVAL_LSB = S_WIDX_LSB + IDX_W;
    localparam int S_KEY_LSB  = S_WVAL_LSB + WORD_W;
    localparam int S_LOW_LSB  = S_KEY_LSB + WORD_W;
    localparam int S_HIGH_LSB = S_LOW_LSB + IDX_W;
    localparam int S_FIELDS_W = S_HIGH_LSB + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int M_TDATA_W = ((POS_W + 7) / 8) * 8;

    // Action codes carried on s_tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PROBE,
        ST_DONE
    } bsst_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic write;   // store the accepted entry
        logic load;    // capture key and bounds
        logic issue;   // compute mid and read the table
        logic step;    // compare and narrow the bounds
        logic push;    // move the result into the output register
    } bsst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic crossed;  // low bound above high bound
        logic equal;    // probed entry matches the key
        logic out_busy; // output register full and not taken this cycle
    } bsst_status_t;

endpackage

>>> hw/rtl/bsst_ctrl.sv
// Controller state machine for the sorted-table search.
module bsst_ctrl
    import bsst_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_action,
    output logic         s_tready,
    input  bsst_status_t status,
    output bsst_cmd_t    cmd
);

    bsst_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_action == ACT_SEARCH) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.crossed) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (status.equal) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.write = s_tvalid && s_action == ACT_WRITE;
                cmd.load  = s_tvalid && s_action == ACT_SEARCH;
            end
            ST_CHECK: begin
                cmd.issue = !status.crossed;
            end
            ST_PROBE: begin
                cmd.step = 1'b1;
            end
            ST_DONE: begin
                cmd.push = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/bsst_dpath.sv
// Datapath: table memory, bound registers, compare and output register.
module bsst_dpath
    import bsst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsst_cmd_t         cmd,
    output bsst_status_t      status,
    input  logic [IDX_W-1:0]  write_index,
    input  logic [WORD_W-1:0] write_value,
    input  logic [WORD_W-1:0] search_key,
    input  logic [IDX_W-1:0]  low_bound,
    input  logic [IDX_W-1:0]  high_bound,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_found,
    output logic [POS_W-1:0]  out_position
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;
    localparam int EXT_W = (VALUE_WIDTH > WORD_W) ? VALUE_WIDTH : WORD_W;

    logic [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];

    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic signed [BND_W-1:0] lo_reg, hi_reg;
    logic [POS_W-1:0]       mid_reg;
    logic                   hit_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [POS_W-1:0]       out_pos_reg;

    logic [IXW-1:0]          widx_ext;
    logic [IXW-1:0]          mid_ext;
    logic                    wr_in_range;
    logic [EXT_W-1:0]        wval_ext, key_ext;
    logic signed [BND_W-1:0] hi_sat;
    logic signed [BND_W-1:0] mid_sum;
    logic signed [BND_W-1:0] mid_calc;
    logic signed [BND_W-1:0] mid_bnd;
    logic                    gt;

    // Words wider than the port field are zero-extended, narrower ones truncated
    assign wval_ext = EXT_W'(write_value);
    assign key_ext  = EXT_W'(search_key);

    // Address forms of the write index and the probe point
    assign widx_ext    = IXW'(write_index);
    assign wr_in_range = 32'(write_index) < 32'(TABLE_DEPTH);
    assign mid_sum     = lo_reg + hi_reg;
    assign mid_calc    = mid_sum >>> 1;
    assign mid_ext     = IXW'(mid_calc[POS_W-1:0]);
    assign mid_bnd     = BND_W'(mid_reg);

    // Clamp the high bound to the last table entry
    assign hi_sat = (32'(high_bound) > 32'(TABLE_DEPTH - 1)) ?
                    BND_W'(TABLE_DEPTH - 1) : BND_W'(high_bound);

    // Signed compare of the probed entry against the key
    assign gt = $signed(rd_data_reg) > $signed(key_reg);

    assign status.crossed  = lo_reg > hi_reg;
    assign status.equal    = rd_data_reg == key_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    // Table write port
    always_ff @(posedge aclk) begin
        if (cmd.write && wr_in_range) begin
            table_mem[widx_ext[AW-1:0]] <= wval_ext[VALUE_WIDTH-1:0];
        end
    end

    // Table read port and probe point
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_data_reg <= table_mem[mid_ext[AW-1:0]];
            mid_reg     <= mid_calc[POS_W-1:0];
        end
    end

    // Load the key and bounds, then narrow the bounds after each probe
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_ext[VALUE_WIDTH-1:0];
            lo_reg  <= BND_W'(low_bound);
            hi_reg  <= hi_sat;
        end else if (cmd.step && !status.equal) begin
            if (gt) begin
                hi_reg <= mid_bnd - BND_W'(1);
            end else begin
                lo_reg <= mid_bnd + BND_W'(1);
            end
        end
    end

    // Track whether the current search hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_reg <= 1'b0;
        end else if (cmd.step && status.equal) begin
            hit_reg <= 1'b1;
        end
    end

    // Output register: fill on push, drain on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_found_reg <= hit_reg;
            out_pos_reg   <= hit_reg ? mid_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = out_found_reg;
    assign out_position = out_pos_reg;

    // A read is only issued inside valid, uncrossed bounds
    a_issue_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (lo_reg >= 0 && hi_reg < BND_W'(TABLE_DEPTH)))
        else $error("probe issued outside the table");

    // Never overwrite a result that has not been taken
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !(out_valid_reg && !out_ready))
        else $error("result pushed over a pending result");

    // A miss always reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> out_pos_reg == '0)
        else $error("miss with nonzero position");

    // An entry above the key pulls the high bound below the probe point
    a_step_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && !cmd.load && !status.equal && gt) |=>
            hi_reg == $past(mid_bnd) - BND_W'(1))
        else $error("high bound not narrowed");

endmodule

>>> hw/rtl/binary_search_sorted_table.sv
// Top level of the sorted-table binary search block.
//
// Usage:
//   Input stream s_*: s_tuser carries the action (0 write, 1 search).
//   A write transaction stores write_value at write_index and gives no
//   result; an index past the table is dropped. A search transaction
//   carries a key and an inclusive low/high bound pair; high_bound is clamped
//   to the last entry. Output stream m_*: one transaction per search, with
//   found on m_tuser and the matching position on m_tdata (0 on a miss).
//   A search makes P probes (at most 11 for a 1024-entry span). Each probe
//   is the registered read of the table read port followed by the compare.
//   A hit ends at the compare, a miss at a bound check that finds the bounds crossed.
//   s_tready returns in the cycle after the result is pushed. The block works
//   on one search at a time; s_tready is high only between searches.
//   A finished result sits in an output register; the next transaction is
//   accepted while it waits. When the receiver stalls with a result pending,
//   the following search holds in its final state until the register drains.
//   Reset clears control state only; table contents are undefined until
//   written, and no clearing pass runs.
module binary_search_sorted_table
    import bsst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: write_index[9:0], write_value[41:10], search_key[73:42],
    //          low_bound[83:74], high_bound[93:84], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: action
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: position[9:0], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: found
    output logic                 m_tuser
);

    bsst_cmd_t        cmd;
    bsst_status_t     status;
    logic [POS_W-1:0] position;

    bsst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsst_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .write_index  (s_tdata[S_WIDX_LSB +: IDX_W]),
        .write_value  (s_tdata[S_WVAL_LSB +: WORD_W]),
        .search_key   (s_tdata[S_KEY_LSB +: WORD_W]),
        .low_bound    (s_tdata[S_LOW_LSB +: IDX_W]),
        .high_bound   (s_tdata[S_HIGH_LSB +: IDX_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_found    (m_tuser),
        .out_position (position)
    );

    // Pad the position to whole bytes
    assign m_tdata = M_TDATA_W'(position);

endmodule

>>> tb/sv/binary_search_sorted_table_tb.sv
// Self-checking testbench for the sorted-table binary search block.
`timescale 1ns / 100ps

module binary_search_sorted_table_tb;
    import bsst_pkg::*;

    localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int OPS_PER_PHASE  = 310;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    // Longest search of 11 probes, with margin
    localparam int DRAIN_CYCLES   = 2 * 11 + 3 + 10;

    localparam logic [WORD_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] VALUE_MAX = 32'h7fff_ffff;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  write_index;
        logic [WORD_W-1:0] write_value;
        logic [WORD_W-1:0] search_key;
        logic [IDX_W-1:0]  low_bound;
        logic [IDX_W-1:0]  high_bound;
    } table_op_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_answer_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Stimulus side: transactions still to send and which entries hold data
    table_op_t         op_queue[$];
    bit                loaded[TABLE_DEPTH];
    logic [WORD_W-1:0] loaded_value[TABLE_DEPTH];
    int                ops_queued = 0;

    // Prediction side: table image as the block sees it, answers in flight
    logic [WORD_W-1:0] table_image[TABLE_DEPTH];
    search_answer_t    search_answers[$];

    idle_mode_t idle_mode    = IDLE_NONE;
    int         fail_count   = 0;
    int         results_seen = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    int         stall_cycles = 0;
    table_op_t  drv_op;

    binary_search_sorted_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Generate clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Bisect the table image between the bounds, signed compare
    function automatic search_answer_t bisect_table(input logic [WORD_W-1:0] key,
                                                    input logic [IDX_W-1:0] lo_b,
                                                    input logic [IDX_W-1:0] hi_b);
        search_answer_t ans;
        int lo;
        int hi;
        int mid;
        bit done;
        ans.found    = 1'b0;
        ans.position = '0;
        lo   = int'(lo_b);
        hi   = int'(hi_b);
        done = 1'b0;
        if (hi > TABLE_DEPTH - 1)
            hi = TABLE_DEPTH - 1;
        while (!done && lo <= hi) begin
            mid = (lo + hi) >> 1;
            if ($signed(table_image[mid]) > $signed(key)) begin
                hi = mid - 1;
            end else if ($signed(table_image[mid]) < $signed(key)) begin
                lo = mid + 1;
            end else begin
                ans.found    = 1'b1;
                ans.position = mid[POS_W-1:0];
                done         = 1'b1;
            end
        end
        return ans;
    endfunction

    function automatic void queue_write(input int idx, input logic [WORD_W-1:0] val);
        table_op_t op;
        op             = '0;
        op.action      = ACT_WRITE;
        op.write_index = idx[IDX_W-1:0];
        op.write_value = val;
        op.search_key  = $urandom;
        op.low_bound   = IDX_W'($urandom);
        op.high_bound  = IDX_W'($urandom);
        loaded[idx]       = 1'b1;
        loaded_value[idx] = val;
        op_queue.push_back(op);
        ops_queued++;
    endfunction

    // Callers keep the bounds inside loaded entries or crossed
    function automatic void queue_search(input logic [WORD_W-1:0] key, input int lo,
                                         input int hi);
        table_op_t op;
        op             = '0;
        op.action      = ACT_SEARCH;
        op.write_index = IDX_W'($urandom);
        op.write_value = $urandom;
        op.search_key  = key;
        op.low_bound   = lo[IDX_W-1:0];
        op.high_bound  = hi[IDX_W-1:0];
        op_queue.push_back(op);
        ops_queued++;
    endfunction

    // Drive the input stream and predict each accepted transaction
    always @(posedge aclk) begin
        logic [S_TDATA_W-1:0] word;
        int gap_pct;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (drv_op.action == ACT_WRITE) begin
                    if (drv_op.write_index < TABLE_DEPTH)
                        table_image[drv_op.write_index] = drv_op.write_value;
                end else begin
                    search_answers.push_back(bisect_table(drv_op.search_key,
                                                          drv_op.low_bound,
                                                          drv_op.high_bound));
                end
            end
            gap_pct = (idle_mode == IDLE_SENDER) ? 81 : (idle_mode == IDLE_BOTH) ? 38 : 0;
            // Offer the next transaction once the slot is free
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    drv_op = op_queue.pop_front();
                    word = '0;
                    word[S_WIDX_LSB +: IDX_W]  = drv_op.write_index;
                    word[S_WVAL_LSB +: WORD_W] = drv_op.write_value;
                    word[S_KEY_LSB +: WORD_W]  = drv_op.search_key;
                    word[S_LOW_LSB +: IDX_W]   = drv_op.low_bound;
                    word[S_HIGH_LSB +: IDX_W]  = drv_op.high_bound;
                    s_tdata  <= word;
                    s_tuser  <= drv_op.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check results against the oldest prediction and drive m_tready
    always @(posedge aclk) begin
        search_answer_t want;
        int stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (search_answers.size() == 0) begin
                    $error("unexpected result: found %0d position %0d",
                           m_tuser, m_tdata[POS_W-1:0]);
                    fail_count++;
                end else begin
                    want = search_answers.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[POS_W-1:0] !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position,
                               m_tdata[POS_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:POS_W] !== '0) begin
                        $error("tdata pad: expected 0, got %0h", m_tdata[M_TDATA_W-1:POS_W]);
                        fail_count++;
                    end
                end
            end
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 81 : (idle_mode == IDLE_BOTH) ? 38 : 0;
            // Hold off once for a long stretch so the block backs up
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Fill the stimulus queue phase by phase, then wait for the block to drain
    initial begin
        int base;
        int len;
        int lo;
        int hi;
        int k;
        int goal;
        int unsigned stride;
        longint v;
        logic [WORD_W-1:0] key;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < 4; p++) begin
            idle_mode = idle_mode_t'(p);
            if (p == 0) begin
                // Small sorted run at the bottom, extremes at the top
                queue_write(0, 32'h8000_0001);
                queue_write(1, -32'sd5);
                queue_write(2, 32'd0);
                queue_write(3, 32'd7);
                queue_write(4, 32'd1000);
                queue_write(5, VALUE_MAX);
                queue_write(1022, VALUE_MIN);
                queue_write(1023, VALUE_MAX);
                // Key below every entry: high bound steps below zero
                queue_search(VALUE_MIN, 0, 5);
                queue_search(VALUE_MAX, 0, 5);
                queue_search(32'd7, 0, 5);
                queue_search(32'd1, 0, 5);
                queue_search(-32'sd5, 0, 5);
                queue_search(32'h8000_0001, 0, 0);
                queue_search(VALUE_MIN, 1022, 1023);
                queue_search(VALUE_MAX, 1022, 1023);
                queue_search(32'd0, 1022, 1023);
                queue_search(32'd7, 3, 3);
                // Crossed bounds end at once
                queue_search(32'd7, 5, 2);
                queue_search(VALUE_MAX, 1023, 0);
                // Break the order and search again
                queue_write(2, 32'd5000);
                queue_search(32'd7, 0, 5);
                queue_search(32'd5000, 0, 5);
            end

            goal = ops_queued + OPS_PER_PHASE;
            while (ops_queued < goal) begin
                case ($urandom_range(0, 7))
                    0: begin
                        // Lone write anywhere
                        queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
                    end
                    1: begin
                        // Crossed bounds read nothing
                        lo = $urandom_range(1, TABLE_DEPTH - 1);
                        hi = $urandom_range(0, lo - 1);
                        queue_search($urandom, lo, hi);
                    end
                    default: begin
                        // Load an ascending run, then search inside it
                        len = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 128)
                                                           : $urandom_range(1, 32);
                        base = $urandom_range(0, TABLE_DEPTH - len);
                        case ($urandom_range(0, 3))
                            0:       stride = 3;
                            1:       stride = 1000;
                            2:       stride = 1 << 24;
                            default: stride = 1 << 28;
                        endcase
                        v = ($urandom_range(0, 7) == 0) ? longint'($signed(VALUE_MIN))
                                                        : longint'($signed($urandom));
                        for (int i = 0; i < len; i++) begin
                            if (i > 0)
                                v = v + $urandom_range(0, stride);
                            if (v > longint'($signed(VALUE_MAX)))
                                v = longint'($signed(VALUE_MAX));
                            if (i == len - 1 && $urandom_range(0, 7) == 0)
                                v = longint'($signed(VALUE_MAX));
                            queue_write(base + i, v[WORD_W-1:0]);
                        end
                        // Sometimes spoil one entry of the run
                        if ($urandom_range(0, 5) == 0)
                            queue_write($urandom_range(base, base + len - 1), $urandom);
                        repeat ($urandom_range(3, 8)) begin
                            lo = $urandom_range(base, base + len - 1);
                            hi = $urandom_range(lo, base + len - 1);
                            // Widen to the whole loaded stretch now and then
                            if ($urandom_range(0, 3) == 0) begin
                                while (lo > 0 && loaded[lo - 1])
                                    lo--;
                                while (hi < TABLE_DEPTH - 1 && loaded[hi + 1])
                                    hi++;
                            end
                            k = $urandom_range(lo, hi);
                            case ($urandom_range(0, 5))
                                3:       key = loaded_value[k] + 1;
                                4:       key = loaded_value[k] - 1;
                                5:       key = $urandom;
                                default: key = loaded_value[k];
                            endcase
                            queue_search(key, lo, hi);
                        end
                    end
                endcase
            end

            // Wait until every transaction is sent and every result has come back
            while (op_queue.size() != 0 || s_tvalid || search_answers.size() != 0)
                @(negedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
